// ----- rtl/core/twc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the text window engine.
package twc_pkg;

   // Screen store geometry
   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 128;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int CELLS    = MAX_ROWS * MAX_COLS;

   // Row count and scroll modulus arithmetic (values 1 .. MAX_ROWS)
   localparam int RCNT_W    = ROW_W + 1;
   localparam int DIV_CNT_W = $clog2(RCNT_W);

   // Character and register widths
   localparam int CHAR_W      = 7;
   localparam int ROWS_CFG_W  = 6;
   localparam int COLS_CFG_W  = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;

   // Register reset values
   localparam logic [CHAR_W-1:0]     RST_ERASE  = 7'd8;
   localparam logic [CHAR_W-1:0]     RST_WERASE = 7'd23;
   localparam logic [CHAR_W-1:0]     RST_KILL   = 7'd21;
   localparam logic [ROWS_CFG_W-1:0] RST_ROWS   = 6'd12;
   localparam logic [COLS_CFG_W-1:0] RST_COLS   = 8'd80;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_TAB   = 7'd9;
   localparam logic [CHAR_W-1:0] CH_NL    = 7'd10;
   localparam logic [CHAR_W-1:0] CH_FF    = 7'd12;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
   localparam logic [CHAR_W-1:0] CH_CARET = 7'd94;
   localparam int                CTRL_MASK = 63;
   localparam int                GLYPH_OFS = 64;
   localparam int                TAB_STOP  = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ERASE  = 3'd0,
      CSR_WERASE = 3'd1,
      CSR_KILL   = 3'd2,
      CSR_ROWS   = 3'd3,
      CSR_COLS   = 3'd4
   } twc_csr_idx_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_RD_ISSUE,
      S_RD_CAP,
      S_ERASE,
      S_WE_RD,
      S_WE_CMP,
      S_WE_BLANK,
      S_KILL,
      S_PUT,
      S_TAB,
      S_CARET_CHK,
      S_DIV,
      S_COMMIT,
      S_BLANK_A,
      S_BLANK_B,
      S_DONE
   } twc_state_type;

   typedef enum logic [2:0] {
      ADDR_CLEAR,
      ADDR_READ,
      ADDR_CUR,
      ADDR_CUR_DEC,
      ADDR_SCAN_DEC,
      ADDR_BLANK
   } twc_addr_sel_type;

   typedef enum logic [1:0] {
      WD_SPACE,
      WD_CARET,
      WD_GLYPH,
      WD_CHAR
   } twc_wdata_sel_type;

   typedef enum logic [1:0] {
      COL_HOLD,
      COL_INC,
      COL_DEC,
      COL_ZERO
   } twc_col_op_type;

   typedef struct packed {
      logic              load_item;
      logic              mem_we;
      logic              mem_re;
      twc_addr_sel_type  addr_sel;
      twc_wdata_sel_type wdata_sel;
      twc_col_op_type    col_op;
      logic              row_commit;
      logic              div_start;
      logic              div_step;
      logic              clr_step;
      logic              blank_next;
      logic              bc_step;
      logic              scan_load;
      logic              scan_dec;
      logic              tgt_load;
      logic              second_set;
      logic              phase_set;
      logic              rd_cap;
      logic              emit;
   } twc_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_read;
      logic is_nl;
      logic is_erase;
      logic is_werase;
      logic is_kill;
      logic is_ff;
      logic is_tab;
      logic is_ctrl;
      logic at_wrap;
      logic div_last;
      logic bc_last;
      logic scan_zero;
      logic col_gt_scan;
      logic col_lt_tgt;
      logic rd_space;
      logic second;
      logic phase;
   } twc_sts_type;

endpackage

// ----- rtl/core/twc_rowmod.sv -----
`timescale 1ns / 1ps
// Iterative remainder unit: next row index modulo the rows in use, one bit per cycle.
module twc_rowmod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        step,
   input  logic [twc_pkg::RCNT_W-1:0]  dividend,
   input  logic [twc_pkg::RCNT_W-1:0]  divisor,
   output logic [twc_pkg::ROW_W-1:0]   remainder,
   output logic                        last
);

   logic [twc_pkg::RCNT_W-1:0]    rem_ff, rem_in;
   logic [twc_pkg::RCNT_W-1:0]    dvd_ff, dvd_in;
   logic [twc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [twc_pkg::RCNT_W-1:0]    trial;

   // remainder stays below the divisor, so its top bit is free for the shifted-in bit
   assign trial = {rem_ff[twc_pkg::ROW_W-1:0], dvd_ff[twc_pkg::RCNT_W-1]};

   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         dvd_in = dividend;
         cnt_in = '0;
      end else if (step) begin
         rem_in = (trial >= divisor) ? trial - divisor : trial;
         dvd_in = {dvd_ff[twc_pkg::RCNT_W-2:0], 1'b0};
         cnt_in = cnt_ff + twc_pkg::DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign remainder = rem_ff[twc_pkg::ROW_W-1:0];
   assign last      = (cnt_ff == twc_pkg::DIV_CNT_W'(twc_pkg::RCNT_W - 1));

endmodule

// ----- rtl/core/twc_dp.sv -----
`timescale 1ns / 1ps
// Datapath: registers, cursor, screen store, counters and the row modulus unit.
module twc_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  twc_pkg::twc_cmd_type            cmd,
   output twc_pkg::twc_sts_type            sts,
   input  logic                            req_opcode,
   input  logic [twc_pkg::CHAR_W-1:0]      req_character,
   input  logic [twc_pkg::ROW_W-1:0]       req_read_row,
   input  logic [twc_pkg::COL_W-1:0]       req_read_col,
   input  logic                            req_end_of_message,
   input  logic                            csr_we,
   input  logic [twc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [twc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic [twc_pkg::ROW_W-1:0]       cursor_row,
   output logic [twc_pkg::COL_W-1:0]       cursor_col,
   output logic [twc_pkg::CHAR_W-1:0]      read_char,
   output logic                            message_done
);

   // configuration registers
   logic [twc_pkg::CHAR_W-1:0]     erase_ff, werase_ff, kill_ff;
   logic [twc_pkg::ROWS_CFG_W-1:0] rows_ff;
   logic [twc_pkg::COLS_CFG_W-1:0] cols_ff;

   // item registers
   logic                       op_ff, eom_ff;
   logic [twc_pkg::CHAR_W-1:0] ch_ff;
   logic [twc_pkg::ROW_W-1:0]  rr_ff;
   logic [twc_pkg::COL_W-1:0]  rc_ff;

   // cursor and walkers
   logic [twc_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [twc_pkg::COL_W-1:0]  col_ff, col_in;
   logic [twc_pkg::ADDR_W-1:0] clr_ff, clr_in;
   logic [twc_pkg::COL_W-1:0]  bc_ff, bc_in;
   logic [twc_pkg::COL_W-1:0]  scan_ff, tgt_ff;
   logic                       second_ff, second_in;
   logic                       phase_ff, phase_in;
   logic [twc_pkg::CHAR_W-1:0] rdchar_ff;

   // screen store
   logic [twc_pkg::CHAR_W-1:0] mem [0:twc_pkg::CELLS-1];
   logic [twc_pkg::CHAR_W-1:0] rdata_ff;
   logic [twc_pkg::ADDR_W-1:0] addr;
   logic [twc_pkg::CHAR_W-1:0] wdata;

   logic [twc_pkg::RCNT_W-1:0] rows_eff, row_p1;
   logic [twc_pkg::ROW_W-1:0]  nrow, rem;
   logic [twc_pkg::COL_W-1:0]  colsm1, col_dec, tgt;
   logic [twc_pkg::COL_W:0]    tab_next;
   logic                       div_last;

   // window size, clamped
   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = twc_pkg::RCNT_W'(1);
      end else if (rows_ff > twc_pkg::ROWS_CFG_W'(twc_pkg::MAX_ROWS)) begin
         rows_eff = twc_pkg::RCNT_W'(twc_pkg::MAX_ROWS);
      end else begin
         rows_eff = twc_pkg::RCNT_W'(rows_ff);
      end
      if (cols_ff < twc_pkg::COLS_CFG_W'(2)) begin
         colsm1 = twc_pkg::COL_W'(1);
      end else if (cols_ff > twc_pkg::COLS_CFG_W'(twc_pkg::MAX_COLS)) begin
         colsm1 = twc_pkg::COL_W'(twc_pkg::MAX_COLS - 1);
      end else begin
         colsm1 = twc_pkg::COL_W'(cols_ff - twc_pkg::COLS_CFG_W'(1));
      end
   end

   assign row_p1  = twc_pkg::RCNT_W'(row_ff) + twc_pkg::RCNT_W'(1);
   assign nrow    = (row_p1 == rows_eff) ? '0 : row_p1[twc_pkg::ROW_W-1:0];
   assign col_dec = (col_ff == '0) ? '0 : col_ff - twc_pkg::COL_W'(1);

   assign tab_next = {1'b0, col_ff | twc_pkg::COL_W'(twc_pkg::TAB_STOP - 1)}
                     + (twc_pkg::COL_W + 1)'(1);
   assign tgt      = (tab_next > {1'b0, colsm1}) ? colsm1 : tab_next[twc_pkg::COL_W-1:0];

   twc_rowmod u_rowmod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .step      (cmd.div_step),
      .dividend  (row_p1),
      .divisor   (rows_eff),
      .remainder (rem),
      .last      (div_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_ff  <= twc_pkg::RST_ERASE;
         werase_ff <= twc_pkg::RST_WERASE;
         kill_ff   <= twc_pkg::RST_KILL;
         rows_ff   <= twc_pkg::RST_ROWS;
         cols_ff   <= twc_pkg::RST_COLS;
      end else if (csr_we) begin
         unique case (csr_index)
            twc_pkg::CSR_ERASE:  erase_ff  <= csr_wdata[twc_pkg::CHAR_W-1:0];
            twc_pkg::CSR_WERASE: werase_ff <= csr_wdata[twc_pkg::CHAR_W-1:0];
            twc_pkg::CSR_KILL:   kill_ff   <= csr_wdata[twc_pkg::CHAR_W-1:0];
            twc_pkg::CSR_ROWS:   rows_ff   <= csr_wdata[twc_pkg::ROWS_CFG_W-1:0];
            twc_pkg::CSR_COLS:   cols_ff   <= csr_wdata[twc_pkg::COLS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // address and write data
   always_comb begin
      unique case (cmd.addr_sel)
         twc_pkg::ADDR_CLEAR:    addr = clr_ff;
         twc_pkg::ADDR_READ:     addr = {rr_ff, rc_ff};
         twc_pkg::ADDR_CUR:      addr = {row_ff, col_ff};
         twc_pkg::ADDR_CUR_DEC:  addr = {row_ff, col_dec};
         twc_pkg::ADDR_SCAN_DEC: addr = {row_ff, scan_ff - twc_pkg::COL_W'(1)};
         twc_pkg::ADDR_BLANK:    addr = {(cmd.blank_next ? nrow : row_ff), bc_ff};
         default:                addr = {row_ff, col_ff};
      endcase
      unique case (cmd.wdata_sel)
         twc_pkg::WD_SPACE: wdata = twc_pkg::CH_SPACE;
         twc_pkg::WD_CARET: wdata = twc_pkg::CH_CARET;
         twc_pkg::WD_GLYPH: wdata = (ch_ff & twc_pkg::CHAR_W'(twc_pkg::CTRL_MASK))
                                    + twc_pkg::CHAR_W'(twc_pkg::GLYPH_OFS);
         twc_pkg::WD_CHAR:  wdata = ch_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[addr] <= wdata;
      end
      if (cmd.mem_re) begin
         rdata_ff <= mem[addr];
      end
   end

   // cursor and control counters
   always_comb begin
      unique case (cmd.col_op)
         twc_pkg::COL_HOLD: col_in = col_ff;
         twc_pkg::COL_INC:  col_in = col_ff + twc_pkg::COL_W'(1);
         twc_pkg::COL_DEC:  col_in = col_dec;
         twc_pkg::COL_ZERO: col_in = '0;
      endcase
      row_in    = cmd.row_commit ? rem : row_ff;
      clr_in    = cmd.clr_step ? clr_ff + twc_pkg::ADDR_W'(1) : clr_ff;
      bc_in     = cmd.bc_step ? bc_ff + twc_pkg::COL_W'(1) : bc_ff;
      second_in = second_ff;
      phase_in  = phase_ff;
      if (cmd.load_item) begin
         second_in = 1'b0;
         phase_in  = 1'b0;
      end
      if (cmd.second_set) begin
         second_in = 1'b1;
      end
      if (cmd.phase_set) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         col_ff    <= '0;
         clr_ff    <= '0;
         bc_ff     <= '0;
         second_ff <= 1'b0;
         phase_ff  <= 1'b0;
      end else begin
         row_ff    <= row_in;
         col_ff    <= col_in;
         clr_ff    <= clr_in;
         bc_ff     <= bc_in;
         second_ff <= second_in;
         phase_ff  <= phase_in;
      end
   end

   // item payload and walkers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff     <= req_opcode;
         ch_ff     <= req_character;
         rr_ff     <= req_read_row;
         rc_ff     <= req_read_col;
         eom_ff    <= req_end_of_message;
         rdchar_ff <= '0;
      end else if (cmd.rd_cap) begin
         rdchar_ff <= rdata_ff;
      end
      if (cmd.scan_load) begin
         scan_ff <= col_ff;
      end else if (cmd.scan_dec) begin
         scan_ff <= scan_ff - twc_pkg::COL_W'(1);
      end
      if (cmd.tgt_load) begin
         tgt_ff <= tgt;
      end
   end

   always_comb begin
      sts.clr_last    = (clr_ff == '1);
      sts.is_read     = op_ff;
      sts.is_nl       = !op_ff && (ch_ff == twc_pkg::CH_NL);
      sts.is_erase    = !op_ff && (ch_ff == erase_ff);
      sts.is_werase   = !op_ff && (ch_ff == werase_ff);
      sts.is_kill     = !op_ff && (ch_ff == kill_ff);
      sts.is_ff       = !op_ff && (ch_ff == twc_pkg::CH_FF);
      sts.is_tab      = (ch_ff == twc_pkg::CH_TAB);
      sts.is_ctrl     = (ch_ff < twc_pkg::CH_SPACE);
      sts.at_wrap     = (col_ff >= colsm1);
      sts.div_last    = div_last;
      sts.bc_last     = (bc_ff == '1);
      sts.scan_zero   = (scan_ff == '0);
      sts.col_gt_scan = (col_ff > scan_ff);
      sts.col_lt_tgt  = (col_ff < tgt_ff);
      sts.rd_space    = (rdata_ff == twc_pkg::CH_SPACE);
      sts.second      = second_ff;
      sts.phase       = phase_ff;
   end

   assign cursor_row   = row_ff;
   assign cursor_col   = col_ff;
   assign read_char    = rdchar_ff;
   assign message_done = eom_ff;

endmodule

// ----- rtl/core/twc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences clearing, decoding, drawing, editing and scrolling for one word.
module twc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_free,
   input  twc_pkg::twc_sts_type  sts,
   output logic                  req_stall,
   output twc_pkg::twc_cmd_type  cmd
);

   twc_pkg::twc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twc_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != twc_pkg::S_IDLE);
      unique case (state_ff)
         twc_pkg::S_INIT: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = twc_pkg::ADDR_CLEAR;
            cmd.wdata_sel = twc_pkg::WD_SPACE;
            cmd.clr_step  = 1'b1;
            if (sts.clr_last) begin
               state_in = twc_pkg::S_IDLE;
            end
         end
         twc_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = twc_pkg::S_DECODE;
            end
         end
         twc_pkg::S_DECODE: begin
            priority if (sts.is_read) begin
               state_in = twc_pkg::S_RD_ISSUE;
            end else if (sts.is_nl) begin
               cmd.div_start = 1'b1;
               state_in      = twc_pkg::S_DIV;
            end else if (sts.is_erase) begin
               state_in = twc_pkg::S_ERASE;
            end else if (sts.is_werase) begin
               cmd.scan_load = 1'b1;
               state_in      = twc_pkg::S_WE_RD;
            end else if (sts.is_kill) begin
               state_in = twc_pkg::S_KILL;
            end else if (sts.is_ff) begin
               state_in = twc_pkg::S_DONE;
            end else if (sts.at_wrap) begin
               cmd.div_start = 1'b1;
               state_in      = twc_pkg::S_DIV;
            end else begin
               state_in = twc_pkg::S_PUT;
            end
         end
         twc_pkg::S_RD_ISSUE: begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = twc_pkg::ADDR_READ;
            state_in     = twc_pkg::S_RD_CAP;
         end
         twc_pkg::S_RD_CAP: begin
            cmd.rd_cap = 1'b1;
            state_in   = twc_pkg::S_DONE;
         end
         twc_pkg::S_ERASE: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = twc_pkg::ADDR_CUR_DEC;
            cmd.wdata_sel = twc_pkg::WD_SPACE;
            cmd.col_op    = twc_pkg::COL_DEC;
            state_in      = twc_pkg::S_DONE;
         end
         twc_pkg::S_WE_RD: begin
            if (sts.scan_zero) begin
               state_in = twc_pkg::S_WE_BLANK;
            end else begin
               cmd.mem_re   = 1'b1;
               cmd.addr_sel = twc_pkg::ADDR_SCAN_DEC;
               state_in     = twc_pkg::S_WE_CMP;
            end
         end
         twc_pkg::S_WE_CMP: begin
            // first pass skips trailing spaces, second pass skips the word
            if (!sts.phase) begin
               cmd.scan_dec = 1'b1;
               cmd.phase_set = !sts.rd_space;
               state_in     = twc_pkg::S_WE_RD;
            end else if (!sts.rd_space) begin
               cmd.scan_dec = 1'b1;
               state_in     = twc_pkg::S_WE_RD;
            end else begin
               state_in = twc_pkg::S_WE_BLANK;
            end
         end
         twc_pkg::S_WE_BLANK: begin
            if (sts.col_gt_scan) begin
               cmd.mem_we    = 1'b1;
               cmd.addr_sel  = twc_pkg::ADDR_CUR_DEC;
               cmd.wdata_sel = twc_pkg::WD_SPACE;
               cmd.col_op    = twc_pkg::COL_DEC;
            end else begin
               state_in = twc_pkg::S_DONE;
            end
         end
         twc_pkg::S_KILL: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = twc_pkg::ADDR_BLANK;
            cmd.wdata_sel = twc_pkg::WD_SPACE;
            cmd.bc_step   = 1'b1;
            if (sts.bc_last) begin
               cmd.col_op = twc_pkg::COL_ZERO;
               state_in   = twc_pkg::S_DONE;
            end
         end
         twc_pkg::S_PUT: begin
            priority if (sts.is_tab) begin
               cmd.tgt_load = 1'b1;
               state_in     = twc_pkg::S_TAB;
            end else if (sts.is_ctrl && !sts.second) begin
               cmd.mem_we     = 1'b1;
               cmd.addr_sel   = twc_pkg::ADDR_CUR;
               cmd.wdata_sel  = twc_pkg::WD_CARET;
               cmd.col_op     = twc_pkg::COL_INC;
               cmd.second_set = 1'b1;
               state_in       = twc_pkg::S_CARET_CHK;
            end else if (sts.is_ctrl) begin
               cmd.mem_we    = 1'b1;
               cmd.addr_sel  = twc_pkg::ADDR_CUR;
               cmd.wdata_sel = twc_pkg::WD_GLYPH;
               cmd.col_op    = twc_pkg::COL_INC;
               state_in      = twc_pkg::S_DONE;
            end else begin
               cmd.mem_we    = 1'b1;
               cmd.addr_sel  = twc_pkg::ADDR_CUR;
               cmd.wdata_sel = twc_pkg::WD_CHAR;
               cmd.col_op    = twc_pkg::COL_INC;
               state_in      = twc_pkg::S_DONE;
            end
         end
         twc_pkg::S_TAB: begin
            if (sts.col_lt_tgt) begin
               cmd.mem_we    = 1'b1;
               cmd.addr_sel  = twc_pkg::ADDR_CUR;
               cmd.wdata_sel = twc_pkg::WD_SPACE;
               cmd.col_op    = twc_pkg::COL_INC;
            end else begin
               state_in = twc_pkg::S_DONE;
            end
         end
         twc_pkg::S_CARET_CHK: begin
            if (sts.at_wrap) begin
               cmd.div_start = 1'b1;
               state_in      = twc_pkg::S_DIV;
            end else begin
               state_in = twc_pkg::S_PUT;
            end
         end
         twc_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = twc_pkg::S_COMMIT;
            end
         end
         twc_pkg::S_COMMIT: begin
            cmd.row_commit = 1'b1;
            cmd.col_op     = twc_pkg::COL_ZERO;
            state_in       = twc_pkg::S_BLANK_A;
         end
         twc_pkg::S_BLANK_A: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = twc_pkg::ADDR_BLANK;
            cmd.wdata_sel = twc_pkg::WD_SPACE;
            cmd.bc_step   = 1'b1;
            if (sts.bc_last) begin
               state_in = twc_pkg::S_BLANK_B;
            end
         end
         twc_pkg::S_BLANK_B: begin
            cmd.mem_we     = 1'b1;
            cmd.addr_sel   = twc_pkg::ADDR_BLANK;
            cmd.wdata_sel  = twc_pkg::WD_SPACE;
            cmd.blank_next = 1'b1;
            cmd.bc_step    = 1'b1;
            if (sts.bc_last) begin
               state_in = sts.is_nl ? twc_pkg::S_DONE : twc_pkg::S_PUT;
            end
         end
         twc_pkg::S_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = twc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = twc_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/text_window_char_engine.sv -----
`timescale 1ns / 1ps
// Top level of the character-cell text window engine: controller, datapath and result register.
//
// Usage:
//  - Request channel (req_*): one word per character to put (opcode 0) or cell to read
//    (opcode 1). A word is taken when req_valid is high and req_stall is low.
//  - Result channel (rsp_*): exactly one word per request, in order: cursor after the
//    request, the cell read (0 for a put) and the echoed end-of-message flag.
//  - csr_*: register writes by index (erase, word erase, kill, rows, columns); write only
//    while no request is in flight.
//  - Work per request: a newline runs six steps of the row modulus unit, one commit and
//    two 128-cell row blanking sweeps, all through the single-port screen store; a wrap
//    adds that same work to the character. A tab writes one space per padded cell, a
//    control glyph writes a caret and then its glyph, kill blanks the 128 cells of the
//    cursor row, and word erase reads back one cell at a time, then blanks each erased
//    cell. The next word is taken once the block is back in idle after emitting a result.
//  - Reset: registers return to defaults, the cursor homes, then the block sweeps all 4096
//    cells to space, one per cycle, holding req_stall high throughout the sweep.
//  - Stall: the result sits in an output register; while rsp_stall holds it, the engine
//    still accepts and works on the next request and waits at its end for the register.
module text_window_char_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [twc_pkg::CHAR_W-1:0]      req_character,
   input  logic [twc_pkg::ROW_W-1:0]       req_read_row,
   input  logic [twc_pkg::COL_W-1:0]       req_read_col,
   input  logic                            req_end_of_message,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [twc_pkg::ROW_W-1:0]       rsp_cursor_row,
   output logic [twc_pkg::COL_W-1:0]       rsp_cursor_col,
   output logic [twc_pkg::CHAR_W-1:0]      rsp_read_char,
   output logic                            rsp_message_done,
   input  logic                            csr_we,
   input  logic [twc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [twc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   twc_pkg::twc_cmd_type cmd;
   twc_pkg::twc_sts_type sts;

   logic                       out_free;
   logic                       accept;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [twc_pkg::ROW_W-1:0]  row_ff, dp_row;
   logic [twc_pkg::COL_W-1:0]  col_ff, dp_col;
   logic [twc_pkg::CHAR_W-1:0] rchar_ff, dp_rchar;
   logic                       done_ff, dp_done;

   // the result register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   twc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   twc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_opcode),
      .req_character      (req_character),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .req_end_of_message (req_end_of_message),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cursor_row         (dp_row),
      .cursor_col         (dp_col),
      .read_char          (dp_rchar),
      .message_done       (dp_done)
   );

   // load on emit, drop valid once taken, otherwise hold
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         row_ff   <= dp_row;
         col_ff   <= dp_col;
         rchar_ff <= dp_rchar;
         done_ff  <= dp_done;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_row   = row_ff;
   assign rsp_cursor_col   = col_ff;
   assign rsp_read_char    = rchar_ff;
   assign rsp_message_done = done_ff;

   ap_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a held result");

   ap_reset_sweep: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken before the clearing sweep");

   ap_no_early_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> !cmd.emit)
      else $error("result emitted in the cycle after accept");

   ap_taken_drops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !cmd.emit) |=> !rsp_valid_ff)
      else $error("result repeated after it was taken");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the text window engine: directed table, random text, checks.
module tb;

   // Opcodes of a request word, and a register index the block has no register for
   localparam logic                          OP_PUT    = 1'b0;
   localparam logic                          OP_READ   = 1'b1;
   localparam logic [twc_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   localparam int N_DIRECTED      = 23;
   localparam int FIXED_PHASES    = 8;
   localparam int NUM_PHASES      = 11;
   localparam int WORDS_PER_PHASE = 150;
   // Longest single request is a control glyph that scrolls twice, still under this
   localparam int DRAIN_CYCLES    = 600;

   typedef struct packed {
      logic                         op;
      logic [twc_pkg::CHAR_W-1:0]   ch;
      logic [twc_pkg::ROW_W-1:0]    rrow;
      logic [twc_pkg::COL_W-1:0]    rcol;
      logic                         eom;
   } window_item_type;

   typedef struct packed {
      logic [twc_pkg::ROW_W-1:0]    row;
      logic [twc_pkg::COL_W-1:0]    col;
      logic [twc_pkg::CHAR_W-1:0]   rchar;
      logic                         done;
   } cursor_word_type;

   typedef struct packed {
      window_item_type              w;
      logic                         typed;
      cursor_word_type              want;
   } directed_row_type;

   typedef struct packed {
      logic [twc_pkg::CSR_DATA_W-1:0] erase;
      logic [twc_pkg::CSR_DATA_W-1:0] werase;
      logic [twc_pkg::CSR_DATA_W-1:0] kill;
      logic [twc_pkg::CSR_DATA_W-1:0] rows;
      logic [twc_pkg::CSR_DATA_W-1:0] cols;
   } window_setting_type;

   localparam cursor_word_type NO_WANT = '0;

   // Directed table, run under the reset register values (erase 8, word erase 23,
   // kill 21, 12 rows, 80 columns). Rows with typed = 1 carry their expected word;
   // the others are checked against the window model below.
   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      // read fresh store at both corners
      '{'{OP_READ, 7'd0, 5'd0, 7'd0, 1'b1}, 1'b1, '{5'd0, 7'd0, twc_pkg::CH_SPACE, 1'b1}},
      '{'{OP_READ, 7'd0, 5'd31, 7'd127, 1'b0}, 1'b1, '{5'd0, 7'd0, twc_pkg::CH_SPACE, 1'b0}},
      // printable extremes and a short word
      '{'{OP_PUT, 7'd65, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd0, 7'd1, 7'd0, 1'b0}},
      '{'{OP_PUT, 7'd127, 5'd31, 7'd127, 1'b1}, 1'b1, '{5'd0, 7'd2, 7'd0, 1'b1}},
      '{'{OP_PUT, twc_pkg::CH_SPACE, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd0, 7'd3, 7'd0, 1'b0}},
      '{'{OP_PUT, 7'd119, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd0, 7'd4, 7'd0, 1'b0}},
      '{'{OP_PUT, 7'd120, 5'd0, 7'd0, 1'b0}, 1'b0, NO_WANT},
      // word erase, erase, kill, then both erases at column 0
      '{'{OP_PUT, twc_pkg::RST_WERASE, 5'd0, 7'd0, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_PUT, twc_pkg::RST_ERASE, 5'd0, 7'd0, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_PUT, twc_pkg::RST_KILL, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd0, 7'd0, 7'd0, 1'b0}},
      '{'{OP_PUT, twc_pkg::RST_ERASE, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd0, 7'd0, 7'd0, 1'b0}},
      '{'{OP_PUT, twc_pkg::RST_WERASE, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd0, 7'd0, 7'd0, 1'b0}},
      // tab stops, control glyphs at both ends, form feed ignored
      '{'{OP_PUT, twc_pkg::CH_TAB, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd0, 7'd8, 7'd0, 1'b0}},
      '{'{OP_PUT, twc_pkg::CH_TAB, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd0, 7'd16, 7'd0, 1'b0}},
      '{'{OP_PUT, 7'd0, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd0, 7'd18, 7'd0, 1'b0}},
      '{'{OP_PUT, 7'd31, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd0, 7'd20, 7'd0, 1'b0}},
      '{'{OP_PUT, twc_pkg::CH_FF, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd0, 7'd20, 7'd0, 1'b0}},
      '{'{OP_READ, 7'd0, 5'd0, 7'd16, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_READ, 7'd0, 5'd0, 7'd19, 1'b0}, 1'b0, NO_WANT},
      // newline, a glyph on the new row, read it back
      '{'{OP_PUT, twc_pkg::CH_NL, 5'd0, 7'd0, 1'b0}, 1'b1, '{5'd1, 7'd0, 7'd0, 1'b0}},
      '{'{OP_PUT, 7'd27, 5'd0, 7'd0, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_READ, 7'd0, 5'd1, 7'd1, 1'b1}, 1'b0, NO_WANT},
      '{'{OP_PUT, twc_pkg::CH_NL, 5'd0, 7'd0, 1'b1}, 1'b0, NO_WANT}
   };

   // Register settings per phase; phases past FIXED_PHASES draw random values.
   // Extremes: 1 row / 2 columns, 0 rows / 0 columns (clamped up), above-range
   // counts (clamped down), newline as erase, space / tab as kill, erase equal
   // to word erase, and upper bits set on the 7-bit registers.
   localparam window_setting_type FIXED_SETTINGS [FIXED_PHASES] = '{
      '{8'd8,   8'd23,  8'd21,  8'd1,   8'd2},
      '{8'h88,  8'h97,  8'h95,  8'd32,  8'd128},
      '{8'd127, 8'd0,   8'd32,  8'd0,   8'd0},
      '{8'd10,  8'd12,  8'd9,   8'd63,  8'd255},
      '{8'd97,  8'd97,  8'd98,  8'd3,   8'd10},
      '{8'd8,   8'd23,  8'd21,  8'hE1,  8'd129},
      '{8'd8,   8'd23,  8'd21,  8'd12,  8'd20},
      '{8'd127, 8'd127, 8'd127, 8'd2,   8'd1}
   };

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic                              req_opcode = OP_PUT;
   logic [twc_pkg::CHAR_W-1:0]        req_character = '0;
   logic [twc_pkg::ROW_W-1:0]         req_read_row = '0;
   logic [twc_pkg::COL_W-1:0]         req_read_col = '0;
   logic                              req_end_of_message = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [twc_pkg::ROW_W-1:0]         rsp_cursor_row;
   logic [twc_pkg::COL_W-1:0]         rsp_cursor_col;
   logic [twc_pkg::CHAR_W-1:0]        rsp_read_char;
   logic                              rsp_message_done;
   logic                              csr_we = 1'b0;
   logic [twc_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [twc_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   text_window_char_engine dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Window model: screen store, cursor and register copies
   logic [twc_pkg::CHAR_W-1:0]     screen [twc_pkg::MAX_ROWS][twc_pkg::MAX_COLS];
   int                             crow = 0;
   int                             ccol = 0;
   logic [twc_pkg::CHAR_W-1:0]     cfg_erase  = twc_pkg::RST_ERASE;
   logic [twc_pkg::CHAR_W-1:0]     cfg_werase = twc_pkg::RST_WERASE;
   logic [twc_pkg::CHAR_W-1:0]     cfg_kill   = twc_pkg::RST_KILL;
   logic [twc_pkg::ROWS_CFG_W-1:0] cfg_rows   = twc_pkg::RST_ROWS;
   logic [twc_pkg::COLS_CFG_W-1:0] cfg_cols   = twc_pkg::RST_COLS;

   cursor_word_type                cursor_words_q [$];
   int                             mismatches = 0;
   int                             stall_left = 0;
   bit                             calm = 1'b0;

   initial begin
      for (int r = 0; r < twc_pkg::MAX_ROWS; r++)
         for (int c = 0; c < twc_pkg::MAX_COLS; c++)
            screen[r][c] = twc_pkg::CH_SPACE;
   end

   function automatic int rows_eff();
      if (cfg_rows == 0) return 1;
      if (cfg_rows > twc_pkg::MAX_ROWS) return twc_pkg::MAX_ROWS;
      return int'(cfg_rows);
   endfunction

   function automatic int cols_eff();
      if (cfg_cols < 2) return 2;
      if (cfg_cols > twc_pkg::MAX_COLS) return twc_pkg::MAX_COLS;
      return int'(cfg_cols);
   endfunction

   // Blank every cell of a row, whatever the column count in use
   function automatic void blank_row(int r);
      for (int c = 0; c < twc_pkg::MAX_COLS; c++)
         screen[r % twc_pkg::MAX_ROWS][c] = twc_pkg::CH_SPACE;
   endfunction

   // Move to column 0 of the next row and blank it and the one after it
   function automatic void scroll_window();
      int n;
      n = rows_eff();
      crow = (crow + 1) % n;
      ccol = 0;
      blank_row(crow);
      blank_row((crow + 1) % n);
   endfunction

   function automatic void draw_cell(logic [twc_pkg::CHAR_W-1:0] ch);
      screen[crow % twc_pkg::MAX_ROWS][ccol % twc_pkg::MAX_COLS] = ch;
      ccol++;
   endfunction

   // Apply one request to the window model and return the word it should produce
   function automatic cursor_word_type advance_window(window_item_type w);
      int              cols;
      int              first;
      int              target;
      cursor_word_type r;
      r = '0;
      if (w.op == OP_PUT) begin
         cols = cols_eff();
         // newline outranks the editing characters, which outrank form feed
         if (w.ch == twc_pkg::CH_NL) begin
            scroll_window();
         end else if (w.ch == cfg_erase) begin
            if (ccol > 0) ccol--;
            screen[crow][ccol] = twc_pkg::CH_SPACE;
         end else if (w.ch == cfg_werase) begin
            // back over trailing blanks, then over the word before them
            first = ccol;
            while (first > 0 && screen[crow][first-1] == twc_pkg::CH_SPACE) first--;
            while (first > 0 && screen[crow][first-1] != twc_pkg::CH_SPACE) first--;
            for (int j = first; j < ccol; j++)
               screen[crow][j] = twc_pkg::CH_SPACE;
            ccol = first;
         end else if (w.ch == cfg_kill) begin
            blank_row(crow);
            ccol = 0;
         end else if (w.ch != twc_pkg::CH_FF) begin
            if (ccol >= cols - 1) scroll_window();
            if (w.ch == twc_pkg::CH_TAB) begin
               target = (ccol | (twc_pkg::TAB_STOP - 1)) + 1;
               if (target > cols - 1) target = cols - 1;
               while (ccol < target) draw_cell(twc_pkg::CH_SPACE);
            end else if (w.ch < twc_pkg::CH_SPACE) begin
               // caret first; the glyph may land on the next row
               draw_cell(twc_pkg::CH_CARET);
               if (ccol >= cols - 1) scroll_window();
               draw_cell(twc_pkg::CHAR_W'((int'(w.ch) & twc_pkg::CTRL_MASK)
                                          + twc_pkg::GLYPH_OFS));
            end else begin
               draw_cell(w.ch);
            end
         end
      end else begin
         r.rchar = screen[w.rrow][w.rcol];
      end
      r.row  = twc_pkg::ROW_W'(crow);
      r.col  = twc_pkg::COL_W'(ccol);
      r.done = w.eom;
      return r;
   endfunction

   // Idle length: mostly none or short, now and then long; none at all in calm phases
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random request: mostly text with spaces and editing, some reads, some noise
   function automatic window_item_type random_item();
      window_item_type w;
      int              r;
      w.op   = OP_PUT;
      w.ch   = twc_pkg::CHAR_W'($urandom_range(0, 127));
      w.rrow = twc_pkg::ROW_W'($urandom_range(0, 31));
      w.rcol = twc_pkg::COL_W'($urandom_range(0, 127));
      w.eom  = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 99) < 12) begin
         w.op = OP_READ;
         case ($urandom_range(0, 3))
            0: begin
               // any cell of the store, already drawn above
            end
            1: begin
               w.rrow = twc_pkg::ROW_W'(crow);
               w.rcol = twc_pkg::COL_W'(ccol > 0 ? ccol - 1 : 0);
            end
            default: begin
               w.rrow = twc_pkg::ROW_W'($urandom_range(0, rows_eff() - 1));
               w.rcol = twc_pkg::COL_W'($urandom_range(0, cols_eff() - 1));
            end
         endcase
         return w;
      end
      r = $urandom_range(0, 99);
      if (r < 40)      w.ch = twc_pkg::CHAR_W'($urandom_range(33, 127));
      else if (r < 55) w.ch = twc_pkg::CH_SPACE;
      else if (r < 62) w.ch = twc_pkg::CH_NL;
      else if (r < 67) w.ch = cfg_erase;
      else if (r < 72) w.ch = cfg_werase;
      else if (r < 75) w.ch = cfg_kill;
      else if (r < 79) w.ch = twc_pkg::CH_TAB;
      else if (r < 84) w.ch = twc_pkg::CHAR_W'($urandom_range(0, 31));
      else if (r < 86) w.ch = twc_pkg::CH_FF;
      return w;
   endfunction

   // Present one request word, hold it until taken, then log its expected result.
   // Called and returning on a rising-edge time step.
   task automatic send_word(window_item_type w, logic typed, cursor_word_type want);
      int              gap;
      cursor_word_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= w.op;
      req_character      <= w.ch;
      req_read_row       <= w.rrow;
      req_read_col       <= w.rcol;
      req_end_of_message <= w.eom;
      do @(posedge clock); while (req_stall);
      predicted = advance_window(w);
      cursor_words_q.push_back(typed ? want : predicted);
   endtask

   // Hold the sender until every expected word has come back
   task automatic wait_drained();
      do @(posedge clock); while (cursor_words_q.size() != 0);
   endtask

   // One register write; the block takes it at the next rising edge
   task automatic write_reg(logic [twc_pkg::CSR_IDX_W-1:0] idx,
                            logic [twc_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         twc_pkg::CSR_ERASE:  cfg_erase  = data[twc_pkg::CHAR_W-1:0];
         twc_pkg::CSR_WERASE: cfg_werase = data[twc_pkg::CHAR_W-1:0];
         twc_pkg::CSR_KILL:   cfg_kill   = data[twc_pkg::CHAR_W-1:0];
         twc_pkg::CSR_ROWS:   cfg_rows   = data[twc_pkg::ROWS_CFG_W-1:0];
         twc_pkg::CSR_COLS:   cfg_cols   = data[twc_pkg::COLS_CFG_W-1:0];
         default: ;
      endcase
   endtask

   // Result side: check each accepted word against the oldest expectation, and
   // drive rsp_stall with random stretches of back-pressure.
   always @(posedge clock) begin : rsp_side
      cursor_word_type want;
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cursor_words_q.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result word: row %0d col %0d char %0d done %0d",
                           rsp_cursor_row, rsp_cursor_col, rsp_read_char, rsp_message_done);
               mismatches++;
            end else begin
               want = cursor_words_q.pop_front();
               if (rsp_cursor_row !== want.row || rsp_cursor_col !== want.col ||
                   rsp_read_char !== want.rchar || rsp_message_done !== want.done) begin
                  if (mismatches < 10)
                     $display({"result mismatch: expected row %0d col %0d char %0d done %0d,",
                               " got row %0d col %0d char %0d done %0d"},
                              want.row, want.col, want.rchar, want.done,
                              rsp_cursor_row, rsp_cursor_col, rsp_read_char,
                              rsp_message_done);
                  mismatches++;
               end
            end
         end
         if (stall_left == 0) stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      window_setting_type s;
      while (reset) @(posedge clock);

      // Directed table under reset settings; the first word also waits out the
      // store clearing sweep through req_stall.
      for (int k = 0; k < N_DIRECTED; k++)
         send_word(DIRECTED[k].w, DIRECTED[k].typed, DIRECTED[k].want);
      req_valid <= 1'b0;

      // Random phases. Drain before each register update so the block is idle;
      // the cursor and store carry over, so a shrunken window is exercised too.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         if (ph < FIXED_PHASES) begin
            s = FIXED_SETTINGS[ph];
         end else begin
            s.erase  = twc_pkg::CSR_DATA_W'($urandom_range(0, 255));
            s.werase = twc_pkg::CSR_DATA_W'($urandom_range(0, 255));
            s.kill   = twc_pkg::CSR_DATA_W'($urandom_range(0, 255));
            s.rows   = twc_pkg::CSR_DATA_W'($urandom_range(0, 255));
            s.cols   = twc_pkg::CSR_DATA_W'($urandom_range(0, 255));
         end
         write_reg(twc_pkg::CSR_ERASE,  s.erase);
         write_reg(twc_pkg::CSR_WERASE, s.werase);
         write_reg(twc_pkg::CSR_KILL,   s.kill);
         write_reg(twc_pkg::CSR_ROWS,   s.rows);
         write_reg(twc_pkg::CSR_COLS,   s.cols);
         write_reg(CSR_SPARE, twc_pkg::CSR_DATA_W'($urandom_range(0, 255)));
         csr_we <= 1'b0;
         calm = (ph % 3 == 2);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            // mid-phase pause: drop valid and let the pipeline run dry
            if (i == WORDS_PER_PHASE / 2 || $urandom_range(0, 99) == 0) begin
               req_valid <= 1'b0;
               wait_drained();
            end
            send_word(random_item(), 1'b0, NO_WANT);
         end
         req_valid <= 1'b0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && cursor_words_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog, several times the slowest legal run
   initial begin
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
